### hdl/tccur_pkg.sv
`default_nettype none
package tccur_pkg;

  // Default parameter values
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 64;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Fixed cell geometry: 8 x 16 pixels (shifts by 3 and 4 below)
  localparam int CELL_W_SHIFT = 3;
  localparam int CELL_H_SHIFT = 4;
  localparam logic [3:0] UNDERLINE_OFS = 4'd14;   // cell height minus 2
  localparam logic [10:0] UNDERLINE_W  = 11'd8;
  localparam logic [10:0] UNDERLINE_H  = 11'd2;

  // Control characters
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_COLUMN_COUNT = 3'd2,
    REG_ROW_COUNT    = 3'd3,
    REG_TEXT_COLOR   = 3'd4,
    REG_BACK_COLOR   = 3'd5,
    REG_CURSOR_COLOR = 3'd6,
    REG_ENABLED      = 3'd7
  } reg_idx_t;

  // Drawing command codes
  typedef enum logic [1:0] {
    CMD_FILL   = 2'd0,
    CMD_GLYPH  = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_t;

  // Back sequencer phase
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,   // cursor erase, or region fill on clear
    PH_GLYPH  = 2'd1,
    PH_SCROLL = 2'd2,
    PH_DRAW   = 2'd3    // new cursor underline, last command
  } phase_t;

  // Effective configuration seen by front and back
  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [7:0]  cols;      // clamped to 1..MAX_COLUMNS
    logic [6:0]  rows;      // clamped to 1..MAX_ROWS
    logic [7:0]  text_color;
    logic [7:0]  back_color;
    logic [7:0]  cursor_color;
    logic        enabled;
  } cfg_t;

  // One classified request: everything the back needs to draw it
  typedef struct packed {
    logic       clr;
    logic       glyph_en;
    logic [7:0] glyph;
    logic       scroll;
    logic [7:0] ecol;      // old cursor (erase); glyph row is erow
    logic [6:0] erow;
    logic [7:0] gcol;
    logic [7:0] ncol;      // new cursor
    logic [6:0] nrow;
  } plan_t;

endpackage
`default_nettype wire

### hdl/tccur_front.sv
`default_nettype none
module tccur_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tccur_pkg::cfg_t cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_kind,
  input  wire logic [7:0]      in_char_code,
  input  wire logic            q_full,
  output logic                 push,
  output tccur_pkg::plan_t     plan
);

  logic [7:0] col_r, col_nxt;
  logic [6:0] row_r, row_nxt;
  logic       accept;
  logic       lf_wrap;
  logic [6:0] lf_row;
  logic [8:0] tab_t;
  tccur_pkg::plan_t p;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && cfg.enabled;
  assign plan     = p;

  // Line feed outcome from the current row
  assign lf_wrap = ({1'b0, row_r} + 8'd1) >= {1'b0, cfg.rows};
  assign lf_row  = lf_wrap ? 7'(cfg.rows - 7'd1) : 7'(row_r + 7'd1);
  assign tab_t   = ({1'b0, col_r} + 9'd4) & ~9'd3;

  // Classify the request and work out the new cursor
  always_comb begin
    p          = '0;
    p.ecol     = col_r;
    p.erow     = row_r;
    p.gcol     = col_r;
    p.ncol     = col_r;
    p.nrow     = row_r;
    if (in_kind) begin
      p.clr  = 1'b1;
      p.ncol = '0;
      p.nrow = '0;
    end else begin
      case (in_char_code)
        tccur_pkg::CHAR_LF: begin
          p.ncol   = '0;
          p.nrow   = lf_row;
          p.scroll = lf_wrap;
        end
        tccur_pkg::CHAR_CR: begin
          p.ncol = '0;
        end
        tccur_pkg::CHAR_TAB: begin
          if (tab_t >= {1'b0, cfg.cols}) begin
            p.ncol   = '0;
            p.nrow   = lf_row;
            p.scroll = lf_wrap;
          end else begin
            p.ncol = tab_t[7:0];
          end
        end
        tccur_pkg::CHAR_BS: begin
          if (col_r != 8'd0) begin
            p.ncol     = col_r - 8'd1;
            p.gcol     = col_r - 8'd1;
            p.glyph_en = 1'b1;
            p.glyph    = tccur_pkg::CHAR_SPACE;
          end
        end
        default: begin
          p.glyph_en = 1'b1;
          p.glyph    = in_char_code;
          if (({1'b0, col_r} + 9'd1) >= {1'b0, cfg.cols}) begin
            p.ncol   = '0;
            p.nrow   = lf_row;
            p.scroll = lf_wrap;
          end else begin
            p.ncol = col_r + 8'd1;
          end
        end
      endcase
    end
  end

  assign col_nxt = push ? p.ncol : col_r;
  assign row_nxt = push ? p.nrow : row_r;

  // Cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/tccur_queue.sv
`default_nettype none
module tccur_queue #(
  parameter int DEPTH = tccur_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire tccur_pkg::plan_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output tccur_pkg::plan_t      head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  tccur_pkg::plan_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hdl/tccur_back.sv
`default_nettype none
module tccur_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tccur_pkg::cfg_t  cfg,
  input  wire logic             head_valid,
  input  wire tccur_pkg::plan_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_command,
  output logic [12:0]           out_pos_x,
  output logic [12:0]           out_pos_y,
  output logic [10:0]           out_size_w,
  output logic [10:0]           out_size_h,
  output logic [7:0]            out_glyph,
  output logic [7:0]            out_fore_color,
  output logic [7:0]            out_fill_color,
  output logic                  out_last
);

  tccur_pkg::phase_t ph_r, ph_nxt;

  logic        out_valid_r;
  logic [1:0]  command_r, command_nxt;
  logic [12:0] pos_x_r, pos_x_nxt;
  logic [12:0] pos_y_r, pos_y_nxt;
  logic [10:0] size_w_r, size_w_nxt;
  logic [10:0] size_h_r, size_h_nxt;
  logic [7:0]  glyph_r, glyph_nxt;
  logic [7:0]  fore_r, fore_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic        last_r, last_nxt;

  logic        advance, fire;
  logic [7:0]  col_sel;
  logic [6:0]  row_sel;
  logic [3:0]  y_ofs;
  logic [10:0] region_w, region_h;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = advance && head_valid;
  assign region_w = {cfg.cols, 3'b000};
  assign region_h = {cfg.rows, 4'b0000};

  // Next phase and the command of the current phase
  always_comb begin
    ph_nxt      = ph_r;
    pop         = 1'b0;
    col_sel     = '0;
    row_sel     = '0;
    y_ofs       = '0;
    command_nxt = tccur_pkg::CMD_FILL;
    size_w_nxt  = '0;
    size_h_nxt  = '0;
    glyph_nxt   = '0;
    fore_nxt    = '0;
    fill_nxt    = '0;
    last_nxt    = 1'b0;
    case (ph_r)
      tccur_pkg::PH_FIRST: begin
        if (head.clr) begin
          size_w_nxt = region_w;
          size_h_nxt = region_h;
          ph_nxt     = tccur_pkg::PH_DRAW;
        end else begin
          col_sel    = head.ecol;
          row_sel    = head.erow;
          y_ofs      = tccur_pkg::UNDERLINE_OFS;
          size_w_nxt = tccur_pkg::UNDERLINE_W;
          size_h_nxt = tccur_pkg::UNDERLINE_H;
          if (head.glyph_en) begin
            ph_nxt = tccur_pkg::PH_GLYPH;
          end else if (head.scroll) begin
            ph_nxt = tccur_pkg::PH_SCROLL;
          end else begin
            ph_nxt = tccur_pkg::PH_DRAW;
          end
        end
        fore_nxt = cfg.back_color;
      end
      tccur_pkg::PH_GLYPH: begin
        command_nxt = tccur_pkg::CMD_GLYPH;
        col_sel     = head.gcol;
        row_sel     = head.erow;
        glyph_nxt   = head.glyph;
        fore_nxt    = cfg.text_color;
        fill_nxt    = cfg.back_color;
        ph_nxt      = head.scroll ? tccur_pkg::PH_SCROLL : tccur_pkg::PH_DRAW;
      end
      tccur_pkg::PH_SCROLL: begin
        command_nxt = tccur_pkg::CMD_SCROLL;
        size_w_nxt  = region_w;
        size_h_nxt  = region_h;
        fill_nxt    = cfg.back_color;
        ph_nxt      = tccur_pkg::PH_DRAW;
      end
      tccur_pkg::PH_DRAW: begin
        col_sel    = head.ncol;
        row_sel    = head.nrow;
        y_ofs      = tccur_pkg::UNDERLINE_OFS;
        size_w_nxt = tccur_pkg::UNDERLINE_W;
        size_h_nxt = tccur_pkg::UNDERLINE_H;
        fore_nxt   = cfg.cursor_color;
        last_nxt   = 1'b1;
        pop        = fire;
        ph_nxt     = tccur_pkg::PH_FIRST;
      end
      default: begin
        ph_nxt = tccur_pkg::PH_FIRST;
      end
    endcase
    if (!fire) begin
      ph_nxt = ph_r;
    end
  end

  // Pixel position of the selected cell
  assign pos_x_nxt = {1'b0, cfg.origin_x} + {2'b00, col_sel, 3'b000};
  assign pos_y_nxt = {1'b0, cfg.origin_y} + {2'b00, row_sel, 4'b0000} + {9'd0, y_ofs};

  // Phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= tccur_pkg::PH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (advance) begin
        out_valid_r <= head_valid;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (fire) begin
      command_r <= command_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      size_w_r  <= size_w_nxt;
      size_h_r  <= size_h_nxt;
      glyph_r   <= glyph_nxt;
      fore_r    <= fore_nxt;
      fill_r    <= fill_nxt;
      last_r    <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_command    = command_r;
  assign out_pos_x      = pos_x_r;
  assign out_pos_y      = pos_y_r;
  assign out_size_w     = size_w_r;
  assign out_size_h     = size_h_r;
  assign out_glyph      = glyph_r;
  assign out_fore_color = fore_r;
  assign out_fill_color = fill_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

### hdl/text_console_cursor_engine.sv
`default_nettype none
// Character-cell console engine. Each accepted request (a character or a
// clear) yields two to four drawing commands on the out_ channel: cursor
// erase (a region fill for a clear), glyph, scroll up and new cursor
// underline, the final one flagged by out_last. The front classifies a
// request and moves the cursor in the cycle it is accepted, so a new request
// can be taken every cycle while the two-entry queue has room. The back
// sequencer emits one command per cycle through an output register while
// out_ready allows; a character that wraps and scrolls takes all four, and
// sustained throughput is set by that sequencer. Requests taken while the
// console is disabled are consumed and produce nothing. Configuration writes
// are always ready and must only be issued while the engine is idle.
module text_console_cursor_engine #(
  parameter int MAX_COLUMNS = tccur_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tccur_pkg::MAX_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  // requests
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_char_code,
  // drawing commands
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_command,
  output logic [12:0]      out_pos_x,
  output logic [12:0]      out_pos_y,
  output logic [10:0]      out_size_w,
  output logic [10:0]      out_size_h,
  output logic [7:0]       out_glyph,
  output logic [7:0]       out_fore_color,
  output logic [7:0]       out_fill_color,
  output logic             out_last
);

  logic [11:0] origin_x_r, origin_y_r;
  logic [7:0]  column_count_r;
  logic [6:0]  row_count_r;
  logic [7:0]  text_color_r, back_color_r, cursor_color_r;
  logic        enabled_r;

  tccur_pkg::cfg_t  cfg;
  tccur_pkg::plan_t push_data, head_data;
  logic             push, q_full, pop, head_valid;
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= 12'd0;
      origin_y_r     <= 12'd0;
      column_count_r <= 8'd80;
      row_count_r    <= 7'd25;
      text_color_r   <= 8'd15;
      back_color_r   <= 8'd0;
      cursor_color_r <= 8'd14;
      enabled_r      <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        tccur_pkg::REG_ORIGIN_X:     origin_x_r     <= cfg_data;
        tccur_pkg::REG_ORIGIN_Y:     origin_y_r     <= cfg_data;
        tccur_pkg::REG_COLUMN_COUNT: column_count_r <= cfg_data[7:0];
        tccur_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_data[6:0];
        tccur_pkg::REG_TEXT_COLOR:   text_color_r   <= cfg_data[7:0];
        tccur_pkg::REG_BACK_COLOR:   back_color_r   <= cfg_data[7:0];
        tccur_pkg::REG_CURSOR_COLOR: cursor_color_r <= cfg_data[7:0];
        tccur_pkg::REG_ENABLED:      enabled_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective region size: zero counts as one, clamp at the maximum
  always_comb begin
    cfg.origin_x     = origin_x_r;
    cfg.origin_y     = origin_y_r;
    cfg.text_color   = text_color_r;
    cfg.back_color   = back_color_r;
    cfg.cursor_color = cursor_color_r;
    cfg.enabled      = enabled_r;
    if (column_count_r == 8'd0) begin
      cfg.cols = 8'd1;
    end else if ({1'b0, column_count_r} > 9'(MAX_COLUMNS)) begin
      cfg.cols = 8'(MAX_COLUMNS);
    end else begin
      cfg.cols = column_count_r;
    end
    if (row_count_r == 7'd0) begin
      cfg.rows = 7'd1;
    end else if ({1'b0, row_count_r} > 8'(MAX_ROWS)) begin
      cfg.rows = 7'(MAX_ROWS);
    end else begin
      cfg.rows = row_count_r;
    end
  end

  tccur_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .push         (push),
    .plan         (push_data)
  );

  tccur_queue #(
    .DEPTH (tccur_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  tccur_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .head_valid     (head_valid),
    .head           (head_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_command    (out_command),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_size_w     (out_size_w),
    .out_size_h     (out_size_h),
    .out_glyph      (out_glyph),
    .out_fore_color (out_fore_color),
    .out_fill_color (out_fill_color),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire
